/* hdl/bra_pkg.sv */
// ----------------------------------------------------------------------------
// bra_pkg
// Shared codes, sizes and controller/datapath interface types for the bus
// resource allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int IRQ_LINES_DEF    = 16;
  localparam int DMA_CHANNELS_DEF = 8;
  localparam int IO_SLOTS_DEF     = 16;

  localparam int MAP_W     = 16;
  localparam int MAP_IDX_W = 4;
  localparam int ADDR_W    = 16;

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  localparam logic [1:0] KIND_IRQ = 2'd0;
  localparam logic [1:0] KIND_DMA = 2'd1;
  localparam logic [1:0] KIND_IO  = 2'd2;
  localparam logic [1:0] KIND_MEM = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_UNSUP = 2'd3;

  typedef struct packed {
    logic       load;
    logic       bits_exec;
    logic       scan_clr;
    logic       scan_rd;
    logic       rel_apply;
    logic       base_init;
    logic       base_step;
    logic       io_claim;
    logic       res_set;
    logic [1:0] res_status;
  } bra_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] kind;
    logic       holds;
    logic       align_zero;
    logic       scan_last;
    logic       free_found;
    logic       hit;
    logic       over;
  } bra_stat_t;

endpackage

/* hdl/bra_dp.sv */
// ----------------------------------------------------------------------------
// bra_dp
// Datapath: request registers, line and channel lock maps, io slot table
// with a one-port scan engine, and result registers.
// ----------------------------------------------------------------------------
module bra_dp
  import bra_pkg::*;
#(
  parameter int IRQ_LINES    = IRQ_LINES_DEF,
  parameter int DMA_CHANNELS = DMA_CHANNELS_DEF,
  parameter int IO_SLOTS     = IO_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bra_cmd_t          cmd,
  output bra_stat_t         stat,
  input  logic [1:0]        in_op,
  input  logic [1:0]        in_kind,
  input  logic [MAP_W-1:0]  in_candidate_mask,
  input  logic [ADDR_W-1:0] in_min_base,
  input  logic [ADDR_W-1:0] in_max_base,
  input  logic [ADDR_W-1:0] in_alignment,
  input  logic [ADDR_W-1:0] in_range_length,
  input  logic [ADDR_W-1:0] in_current,
  input  logic              in_holds_lock,
  output logic              out_granted,
  output logic [1:0]        out_status,
  output logic [ADDR_W-1:0] out_assignment
);

  localparam int SLOT_W = (IO_SLOTS > 1) ? $clog2(IO_SLOTS) : 1;

  logic [1:0]        op_r;
  logic [1:0]        kind_r;
  logic [MAP_W-1:0]  mask_r;
  logic [ADDR_W-1:0] min_r;
  logic [ADDR_W-1:0] max_r;
  logic [ADDR_W-1:0] align_r;
  logic [ADDR_W-1:0] len_r;
  logic [ADDR_W-1:0] cur_r;
  logic              holds_r;

  logic [IRQ_LINES-1:0]    line_r;
  logic [DMA_CHANNELS-1:0] chan_r;
  logic [IO_SLOTS-1:0]     valid_r;

  logic [ADDR_W-1:0] mem_base [IO_SLOTS];
  logic [ADDR_W-1:0] mem_len  [IO_SLOTS];

  logic [ADDR_W:0]   base_r;
  logic [SLOT_W-1:0] idx_r;
  logic [ADDR_W-1:0] rd_base_r;
  logic [ADDR_W-1:0] rd_len_r;
  logic              rd_vld_r;
  logic              rd_live_r;
  logic [SLOT_W-1:0] rd_idx_r;
  logic              hit_r;
  logic              free_found_r;
  logic [SLOT_W-1:0] free_idx_r;
  logic              match_found_r;
  logic [SLOT_W-1:0] match_idx_r;

  logic              res_grant_r;
  logic [1:0]        res_status_r;
  logic [ADDR_W-1:0] res_assign_r;

  logic [ADDR_W+1:0] b_ext;
  logic [ADDR_W+1:0] end_new;
  logic [ADDR_W+1:0] cb_ext;
  logic [ADDR_W+1:0] end_old;
  logic              coll;
  logic              scan_last;

  logic [MAP_W-1:0]     taken_sel;
  logic [MAP_W-1:0]     taken_rel;
  logic [MAP_W-1:0]     taken_new;
  logic [ADDR_W:0]      first;
  logic [MAP_IDX_W-1:0] pick;
  logic                 found;
  int                   cnt;

  assign scan_last = (idx_r == SLOT_W'(IO_SLOTS - 1));

  always_comb begin
    b_ext   = {1'b0, base_r};
    end_new = b_ext + (ADDR_W+2)'(len_r);
    cb_ext  = (ADDR_W+2)'(rd_base_r);
    end_old = cb_ext + (ADDR_W+2)'(rd_len_r);
    coll    = rd_vld_r && (((b_ext <= cb_ext) && (end_new > cb_ext)) ||
                           ((b_ext >= cb_ext) && (b_ext < end_old)));
  end

  always_comb begin
    cnt       = (kind_r == KIND_IRQ) ? IRQ_LINES : DMA_CHANNELS;
    taken_sel = (kind_r == KIND_IRQ) ? MAP_W'(line_r) : MAP_W'(chan_r);
    taken_rel = taken_sel;
    if ((op_r != OP_ACQUIRE) && holds_r && ({1'b0, cur_r} < (ADDR_W+1)'(cnt))) begin
      taken_rel[cur_r[MAP_IDX_W-1:0]] = 1'b0;
    end
    first = (op_r == OP_ACQUIRE) ? '0 : ({1'b0, cur_r} + 1'b1);
    pick  = '0;
    found = 1'b0;
    for (int b = MAP_W - 1; b >= 0; b--) begin
      if (mask_r[b] && !taken_rel[b] && ((ADDR_W+1)'(b) >= first) && (b < cnt)) begin
        pick  = MAP_IDX_W'(b);
        found = 1'b1;
      end
    end
    taken_new = taken_rel;
    if (found && (op_r != OP_RELEASE)) begin
      taken_new[pick] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      kind_r  <= in_kind;
      mask_r  <= in_candidate_mask;
      min_r   <= in_min_base;
      max_r   <= in_max_base;
      align_r <= in_alignment;
      len_r   <= in_range_length;
      cur_r   <= in_current;
      holds_r <= in_holds_lock;
    end
    if (cmd.base_init) begin
      base_r <= (op_r == OP_ACQUIRE) ? {1'b0, min_r} : ({1'b0, cur_r} + {1'b0, align_r});
    end else if (cmd.base_step) begin
      base_r <= base_r + {1'b0, align_r};
    end
    rd_idx_r <= idx_r;
    rd_vld_r <= valid_r[idx_r];
    if (!cmd.scan_clr && rd_live_r) begin
      if (!free_found_r && !rd_vld_r) begin
        free_idx_r <= rd_idx_r;
      end
      if (!match_found_r && rd_vld_r && (rd_base_r == cur_r)) begin
        match_idx_r <= rd_idx_r;
      end
    end
    if (cmd.bits_exec) begin
      res_status_r <= (op_r == OP_RELEASE || found) ? ST_OK : ST_NONE;
      res_assign_r <= (op_r != OP_RELEASE && found) ? ADDR_W'(pick) : '0;
    end else if (cmd.io_claim) begin
      res_status_r <= ST_OK;
      res_assign_r <= base_r[ADDR_W-1:0];
    end else if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      res_assign_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.io_claim) begin
      mem_base[free_idx_r] <= base_r[ADDR_W-1:0];
      mem_len[free_idx_r]  <= len_r;
    end
    rd_base_r <= mem_base[idx_r];
    rd_len_r  <= mem_len[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r        <= '0;
      chan_r        <= '0;
      valid_r       <= '0;
      idx_r         <= '0;
      rd_live_r     <= 1'b0;
      hit_r         <= 1'b0;
      free_found_r  <= 1'b0;
      match_found_r <= 1'b0;
      res_grant_r   <= 1'b0;
    end else begin
      rd_live_r <= cmd.scan_rd;
      if (cmd.scan_clr) begin
        idx_r <= '0;
      end else if (cmd.scan_rd && !scan_last) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.scan_clr) begin
        hit_r         <= 1'b0;
        free_found_r  <= 1'b0;
        match_found_r <= 1'b0;
      end else if (rd_live_r) begin
        hit_r <= hit_r | coll;
        if (!rd_vld_r) begin
          free_found_r <= 1'b1;
        end
        if (rd_vld_r && (rd_base_r == cur_r)) begin
          match_found_r <= 1'b1;
        end
      end
      if (cmd.bits_exec) begin
        if (kind_r == KIND_IRQ) begin
          line_r <= taken_new[IRQ_LINES-1:0];
        end else begin
          chan_r <= taken_new[DMA_CHANNELS-1:0];
        end
        res_grant_r <= (op_r != OP_RELEASE) && found;
      end else if (cmd.io_claim) begin
        res_grant_r <= 1'b1;
      end else if (cmd.res_set) begin
        res_grant_r <= 1'b0;
      end
      if (cmd.rel_apply && match_found_r) begin
        valid_r[match_idx_r] <= 1'b0;
      end else if (cmd.io_claim) begin
        valid_r[free_idx_r] <= 1'b1;
      end
    end
  end

  always_comb begin
    stat.op         = op_r;
    stat.kind       = kind_r;
    stat.holds      = holds_r;
    stat.align_zero = (align_r == '0);
    stat.scan_last  = scan_last;
    stat.free_found = free_found_r;
    stat.hit        = hit_r;
    stat.over       = (base_r > {1'b0, max_r});
  end

  assign out_granted    = res_grant_r;
  assign out_status     = res_status_r;
  assign out_assignment = res_assign_r;

`ifndef SYNTHESIS
  a_claim_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.io_claim |-> (free_found_r && !valid_r[free_idx_r]))
    else $error("io claim into an occupied slot");

  a_claim_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.io_claim |-> (base_r <= {1'b0, max_r}))
    else $error("io claim beyond max base");

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    res_grant_r |-> (res_status_r == ST_OK))
    else $error("grant with failing status");
`endif

endmodule

/* hdl/bra_ctrl.sv */
// ----------------------------------------------------------------------------
// bra_ctrl
// Controller: accepts a request word, dispatches by kind, sequences the io
// release and collision scans, and strobes the result.
// ----------------------------------------------------------------------------
module bra_ctrl
  import bra_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  bra_stat_t stat,
  output bra_cmd_t  cmd,
  output logic      out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_REL_SCAN,
    S_REL_TAIL,
    S_REL_APPLY,
    S_COL_SCAN,
    S_COL_TAIL,
    S_COL_EVAL
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.op == OP_NOP) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_OK;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (stat.kind == KIND_MEM) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_UNSUP;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (stat.kind != KIND_IO) begin
          cmd.bits_exec = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.base_init = 1'b1;
          cmd.scan_clr  = 1'b1;
          if ((stat.op != OP_ACQUIRE) && stat.holds) begin
            state_nxt = S_REL_SCAN;
          end else if (stat.op == OP_RELEASE) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_OK;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            state_nxt = S_COL_SCAN;
          end
        end
      end
      S_REL_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_REL_TAIL;
        end
      end
      S_REL_TAIL: begin
        state_nxt = S_REL_APPLY;
      end
      S_REL_APPLY: begin
        cmd.rel_apply = 1'b1;
        if (stat.op == OP_RELEASE) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_OK;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_COL_SCAN;
        end
      end
      S_COL_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_COL_TAIL;
        end
      end
      S_COL_TAIL: begin
        state_nxt = S_COL_EVAL;
      end
      S_COL_EVAL: begin
        if (!stat.free_found) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_FULL;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (((stat.op == OP_ADVANCE) && stat.align_zero) || stat.over) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NONE;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (!stat.hit) begin
          cmd.io_claim  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (stat.align_zero) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NONE;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.base_step = 1'b1;
          cmd.scan_clr  = 1'b1;
          state_nxt     = S_COL_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r != S_IDLE))
    else $error("result strobe without work in progress");
`endif

endmodule

/* hdl/bus_resource_allocator.sv */
// ----------------------------------------------------------------------------
// bus_resource_allocator
// Lock maps for interrupt lines and DMA channels plus a table of claimed
// io ranges; acquire, advance and release one assignment per request.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low. Its result is
// on the out_ ports for one cycle with out_valid high and must be captured
// then; the receiver cannot stall. Interrupt, DMA, memory-kind and no-op
// requests are settled in the dispatch state, from which the result and
// strobe are registered. An io request scans the slot table once per
// candidate base tried, plus once when a held range is freed first; its
// single read port takes one slot per cycle. Busy drops in the strobe cycle.
module bus_resource_allocator
  import bra_pkg::*;
#(
  parameter int IRQ_LINES    = IRQ_LINES_DEF,
  parameter int DMA_CHANNELS = DMA_CHANNELS_DEF,
  parameter int IO_SLOTS     = IO_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_op,
  input  logic [1:0]        in_kind,
  input  logic [MAP_W-1:0]  in_candidate_mask,
  input  logic [ADDR_W-1:0] in_min_base,
  input  logic [ADDR_W-1:0] in_max_base,
  input  logic [ADDR_W-1:0] in_alignment,
  input  logic [ADDR_W-1:0] in_range_length,
  input  logic [ADDR_W-1:0] in_current,
  input  logic              in_holds_lock,
  output logic              out_valid,
  output logic              out_granted,
  output logic [1:0]        out_status,
  output logic [ADDR_W-1:0] out_assignment
);

  bra_cmd_t  cmd;
  bra_stat_t stat;

  bra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .stat      (stat),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  bra_dp #(
    .IRQ_LINES    (IRQ_LINES),
    .DMA_CHANNELS (DMA_CHANNELS),
    .IO_SLOTS     (IO_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_op             (in_op),
    .in_kind           (in_kind),
    .in_candidate_mask (in_candidate_mask),
    .in_min_base       (in_min_base),
    .in_max_base       (in_max_base),
    .in_alignment      (in_alignment),
    .in_range_length   (in_range_length),
    .in_current        (in_current),
    .in_holds_lock     (in_holds_lock),
    .out_granted       (out_granted),
    .out_status        (out_status),
    .out_assignment    (out_assignment)
  );

endmodule
